// ===== hdl/alp_pkg.sv =====
// Shared types and constants for the access-log line parser.
package alp_pkg;

    // One input item: a byte of the log line and its end-of-line flag.
    typedef struct packed {
        logic [7:0] byte_value;
        logic       line_end;
    } alp_in_t;

    // One result item, produced on the last byte of each line.
    typedef struct packed {
        logic [1:0]         line_outcome;
        logic signed [31:0] status_value;
        logic signed [31:0] object_bytes;
        logic [31:0]        lines_seen;
        logic [47:0]        bytes_total;
    } alp_out_t;

    // Line outcome codes.
    typedef enum logic [1:0] {
        OUT_OK         = 2'd0,
        OUT_DELIM_MISS = 2'd1,
        OUT_AGENT_BAD  = 2'd2,
        OUT_NUMBER_BAD = 2'd3
    } alp_outcome_t;

    // Phases of the delimiter search.
    typedef enum logic [3:0] {
        PH_SPACE_0      = 4'd0,
        PH_SPACE_1      = 4'd1,
        PH_SPACE_2      = 4'd2,
        PH_REQUEST      = 4'd3,
        PH_STATUS_START = 4'd4,
        PH_SIZE_START   = 4'd5,
        PH_REFERER      = 4'd6,
        PH_AGENT        = 4'd7,
        PH_AGENT_CLOSE  = 4'd8,
        PH_QUOTE_CHECK  = 4'd9,
        PH_DONE_OK      = 4'd10,
        PH_DONE_BAD     = 4'd11
    } alp_phase_t;

    // Modes of a decimal reader.
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_WS    = 3'd1,
        MODE_PLUS  = 3'd2,
        MODE_MINUS = 3'd3,
        MODE_POS   = 3'd4,
        MODE_NEG   = 3'd5,
        MODE_END   = 3'd6,
        MODE_FAIL  = 3'd7
    } alp_mode_t;

    // State of one decimal reader.
    typedef struct packed {
        alp_mode_t          mode;
        logic signed [31:0] acc;
    } alp_reader_t;

    // Result of one delimiter match step.
    typedef struct packed {
        logic       hit;
        logic [1:0] progress;
    } alp_match_t;

    // Character codes.
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BRACKET = 8'h5D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    // Delimiter patterns, first character in the low byte.
    localparam logic [23:0] PAT_REQUEST = {CH_QUOTE, CH_SPACE, CH_BRACKET};
    localparam logic [23:0] PAT_STATUS  = {8'h00, CH_SPACE, CH_QUOTE};
    localparam logic [23:0] PAT_REFERER = {8'h00, CH_QUOTE, CH_SPACE};
    localparam logic [23:0] PAT_AGENT   = {CH_QUOTE, CH_SPACE, CH_QUOTE};

    // Saturation limits of the readers, at the width of the product.
    localparam logic signed [36:0] SAT_MAX = 37'sd2147483647;
    localparam logic signed [36:0] SAT_MIN = -37'sd2147483648;

endpackage

// ===== hdl/access_log_line_parser_core.sv =====
// Top level of the access-log line parser: input register, parse logic and result register.
//
// The block checks lines in combined log format, one byte per item.
// Input channel: byte_valid / byte_ready / byte_item carry one byte of the line and a
// flag on its last byte. Output channel: result_valid / result_ready / result_item
// carry one result per line: the outcome, the parsed status and size, the line count
// and the running sum of sizes of lines that parsed cleanly.
// An accepted byte is held in an input register; the phase machine and both decimal
// readers then update from it, and on a last byte the result is written into the
// result register. A result therefore passes the input register and then the result
// register before it is visible on the output channel.
// Throughput is one byte per cycle while no last byte waits, set by the update loop of
// the parse state (phase, match progress and the multiply-by-ten accumulators).
// When the receiver stalls, bytes that are not the last of a line keep flowing; a last
// byte waits in the input register until the result register is free, and byte_ready
// drops while it waits.
// Reset clears the phase machine, the readers, the line counter and the size sum, and
// empties both registers.
module access_log_line_parser_core
    import alp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     byte_valid,
    output logic     byte_ready,
    input  alp_in_t  byte_item,
    output logic     result_valid,
    input  logic     result_ready,
    output alp_out_t result_item
);

    // Whitespace test: space, tab, LF, VT, FF, CR.
    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // acc * 10 plus or minus one digit, saturated to 32 bits.
    function automatic logic signed [31:0] sat_step(input logic signed [31:0] acc,
                                                    input logic [3:0] d,
                                                    input logic neg);
        logic signed [36:0] wide;
        logic signed [36:0] t;
        wide = 37'(acc);
        t = (wide <<< 3) + (wide <<< 1);
        if (neg)
            t = t - $signed({33'd0, d});
        else
            t = t + $signed({33'd0, d});
        if (t > SAT_MAX)
            t = SAT_MAX;
        else if (t < SAT_MIN)
            t = SAT_MIN;
        return t[31:0];
    endfunction

    // One step of a decimal reader.
    function automatic alp_reader_t feed(input alp_reader_t r, input logic [7:0] c);
        alp_reader_t        n;
        logic               dig;
        logic [3:0]         d;
        logic signed [31:0] dval;
        n    = r;
        dig  = (c >= CH_ZERO) && (c <= CH_NINE);
        d    = c[3:0];
        dval = $signed({28'd0, d});
        case (r.mode)
            MODE_WS:
            begin
                if (is_ws(c))
                    n.mode = MODE_WS;
                else if (c == CH_PLUS)
                    n.mode = MODE_PLUS;
                else if (c == CH_MINUS)
                    n.mode = MODE_MINUS;
                else if (dig)
                begin
                    n.acc  = dval;
                    n.mode = MODE_POS;
                end
                else
                    n.mode = MODE_FAIL;
            end
            MODE_PLUS:
            begin
                if (dig)
                begin
                    n.acc  = dval;
                    n.mode = MODE_POS;
                end
                else
                    n.mode = MODE_FAIL;
            end
            MODE_MINUS:
            begin
                if (dig)
                begin
                    n.acc  = -dval;
                    n.mode = MODE_NEG;
                end
                else
                    n.mode = MODE_FAIL;
            end
            MODE_POS:
            begin
                if (dig)
                    n.acc = sat_step(r.acc, d, 1'b0);
                else
                    n.mode = MODE_END;
            end
            MODE_NEG:
            begin
                if (dig)
                    n.acc = sat_step(r.acc, d, 1'b1);
                else
                    n.mode = MODE_END;
            end
            default:
                n = r;
        endcase
        return n;
    endfunction

    // One step of a substring search for a pattern of two or three characters.
    function automatic alp_match_t match_step(input logic [1:0] prog,
                                              input logic [1:0] len,
                                              input logic [23:0] pat,
                                              input logic [7:0] c);
        alp_match_t m;
        logic [7:0] expect_ch;
        logic [1:0] inc;
        expect_ch = pat[8*prog +: 8];
        m.hit = 1'b0;
        if ((prog < len) && (c == expect_ch))
        begin
            inc = prog + 2'd1;
            if (inc == len)
            begin
                m.hit      = 1'b1;
                m.progress = 2'd0;
            end
            else
                m.progress = inc;
        end
        else
            m.progress = (c == pat[7:0]) ? 2'd1 : 2'd0;
        return m;
    endfunction

    function automatic logic number_ok(input alp_mode_t mode);
        return (mode == MODE_POS) || (mode == MODE_NEG) || (mode == MODE_END);
    endfunction

    // Registers.
    logic        s1_valid_reg, s1_valid_next;
    alp_in_t     s1_item_reg;
    logic        result_valid_reg, result_valid_next;
    alp_out_t    result_item_reg, result_item_next;
    alp_phase_t  phase_reg, phase_next;
    logic [1:0]  progress_reg, progress_next;
    alp_reader_t status_reg, status_next;
    alp_reader_t size_reg, size_next;
    logic [31:0] line_count_reg, line_count_next;
    logic [47:0] size_sum_reg, size_sum_next;

    logic        s1_go;
    logic        fire;
    logic [7:0]  c;
    alp_match_t  m;
    alp_outcome_t outcome;

    // Handshake: a last byte may only move on when the result register is free.
    assign s1_go      = !s1_item_reg.line_end || !result_valid_reg || result_ready;
    assign byte_ready = !s1_valid_reg || s1_go;
    assign fire       = s1_valid_reg && s1_go;
    assign c          = s1_item_reg.byte_value;

    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

    // Phase machine, readers and the result of a finished line.
    always_comb
    begin
        phase_next       = phase_reg;
        progress_next    = progress_reg;
        status_next      = status_reg;
        size_next        = size_reg;
        line_count_next  = line_count_reg;
        size_sum_next    = size_sum_reg;
        result_item_next = result_item_reg;
        outcome          = OUT_OK;
        m                = '0;

        if (fire)
        begin
            status_next = feed(status_reg, c);
            size_next   = feed(size_reg, c);

            unique case (phase_reg)
                PH_SPACE_0:
                    if (c == CH_SPACE) phase_next = PH_SPACE_1;
                PH_SPACE_1:
                    if (c == CH_SPACE) phase_next = PH_SPACE_2;
                PH_SPACE_2:
                    if (c == CH_SPACE) phase_next = PH_REQUEST;
                PH_REQUEST:
                begin
                    m = match_step(progress_reg, 2'd3, PAT_REQUEST, c);
                    progress_next = m.progress;
                    if (m.hit) phase_next = PH_STATUS_START;
                end
                PH_STATUS_START:
                begin
                    m = match_step(progress_reg, 2'd2, PAT_STATUS, c);
                    progress_next = m.progress;
                    if (m.hit)
                    begin
                        phase_next       = PH_SIZE_START;
                        status_next.mode = MODE_WS;
                    end
                end
                PH_SIZE_START:
                    if (c == CH_SPACE)
                    begin
                        phase_next     = PH_REFERER;
                        size_next.mode = MODE_WS;
                    end
                PH_REFERER:
                begin
                    m = match_step(progress_reg, 2'd2, PAT_REFERER, c);
                    progress_next = m.progress;
                    if (m.hit) phase_next = PH_AGENT;
                end
                PH_AGENT:
                begin
                    m = match_step(progress_reg, 2'd3, PAT_AGENT, c);
                    progress_next = m.progress;
                    if (m.hit) phase_next = PH_AGENT_CLOSE;
                end
                PH_AGENT_CLOSE:
                    if (c == CH_QUOTE) phase_next = PH_QUOTE_CHECK;
                PH_QUOTE_CHECK:
                    phase_next = (c == CH_SPACE) ? PH_DONE_BAD : PH_DONE_OK;
                default:
                    phase_next = phase_reg;
            endcase

            if (s1_item_reg.line_end)
            begin
                // Missing delimiter outranks a bad agent end, which outranks a bad number.
                if (phase_next < PH_AGENT_CLOSE)
                    outcome = OUT_DELIM_MISS;
                else if ((phase_next == PH_AGENT_CLOSE) || (phase_next == PH_DONE_BAD))
                    outcome = OUT_AGENT_BAD;
                else if (!number_ok(status_next.mode) || !number_ok(size_next.mode))
                    outcome = OUT_NUMBER_BAD;
                else
                    outcome = OUT_OK;

                line_count_next = line_count_reg + 32'd1;
                result_item_next.line_outcome = outcome;
                result_item_next.lines_seen   = line_count_next;
                if (outcome == OUT_OK)
                begin
                    size_sum_next = size_sum_reg + {{16{size_next.acc[31]}}, size_next.acc};
                    result_item_next.status_value = status_next.acc;
                    result_item_next.object_bytes = size_next.acc;
                end
                else
                begin
                    result_item_next.status_value = '0;
                    result_item_next.object_bytes = '0;
                end
                result_item_next.bytes_total = size_sum_next;

                // Clear all per-line state for the next line.
                phase_next    = PH_SPACE_0;
                progress_next = 2'd0;
                status_next   = '{mode: MODE_IDLE, acc: '0};
                size_next     = '{mode: MODE_IDLE, acc: '0};
            end
        end
    end

    // Occupancy of the input and result registers.
    always_comb
    begin
        if (byte_valid && byte_ready)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (fire && s1_item_reg.line_end)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    // Control and parse state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            phase_reg        <= PH_SPACE_0;
            progress_reg     <= 2'd0;
            status_reg       <= '{mode: MODE_IDLE, acc: '0};
            size_reg         <= '{mode: MODE_IDLE, acc: '0};
            line_count_reg   <= '0;
            size_sum_reg     <= '0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
            phase_reg        <= phase_next;
            progress_reg     <= progress_next;
            status_reg       <= status_next;
            size_reg         <= size_next;
            line_count_reg   <= line_count_next;
            size_sum_reg     <= size_sum_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
            s1_item_reg <= byte_item;
        result_item_reg <= result_item_next;
    end

endmodule

// ===== dv/alp_line_checker.sv =====
// Checker for the access-log line parser: predicts each line result and compares it.
module alp_line_checker
    import alp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            byte_valid,
    input  logic            byte_ready,
    input  alp_in_t         byte_item,
    input  logic            result_valid,
    input  logic            result_ready,
    input  alp_out_t        result_item,
    output int              fail_count,
    output int              pending,
    output int              lines_checked,
    output logic [3:0][31:0] outcome_hits
);

    // Saturation bounds of a decimal reader.
    localparam longint ACC_TOP    = 64'sd2147483647;
    localparam longint ACC_BOTTOM = -64'sd2147483648;

    // Predicted parse state of the current line, plus the running totals.
    alp_phase_t  parse_phase;
    logic [1:0]  delim_progress;
    alp_reader_t status_rd;
    alp_reader_t size_rd;
    logic [31:0] line_count;
    logic [47:0] size_total;

    // Results predicted but not yet seen on the output channel.
    alp_out_t expected_lines[$];

    function automatic logic is_blank(logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // One decimal step with saturation at the signed 32-bit limits.
    function automatic logic signed [31:0] scale_digit(logic signed [31:0] acc, int dv,
                                                       logic neg);
        longint t;
        t = longint'(acc) * 10;
        t = neg ? t - dv : t + dv;
        if (t > ACC_TOP)
        begin
            t = ACC_TOP;
        end
        if (t < ACC_BOTTOM)
        begin
            t = ACC_BOTTOM;
        end
        return t[31:0];
    endfunction

    // Advance one decimal reader by one byte.
    function automatic alp_reader_t read_digit(alp_reader_t r, logic [7:0] c);
        logic        is_dig;
        int          dv;
        alp_reader_t n;
        is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
        dv = int'(c[3:0]);
        n = r;
        case (r.mode)
            MODE_WS:
            begin
                if (is_blank(c))
                begin
                    n.mode = MODE_WS;
                end
                else if (c == CH_PLUS)
                begin
                    n.mode = MODE_PLUS;
                end
                else if (c == CH_MINUS)
                begin
                    n.mode = MODE_MINUS;
                end
                else if (is_dig)
                begin
                    n.acc  = dv;
                    n.mode = MODE_POS;
                end
                else
                begin
                    n.mode = MODE_FAIL;
                end
            end
            MODE_PLUS:
            begin
                n.acc  = is_dig ? dv : r.acc;
                n.mode = is_dig ? MODE_POS : MODE_FAIL;
            end
            MODE_MINUS:
            begin
                n.acc  = is_dig ? -dv : r.acc;
                n.mode = is_dig ? MODE_NEG : MODE_FAIL;
            end
            MODE_POS:
            begin
                n.acc  = is_dig ? scale_digit(r.acc, dv, 1'b0) : r.acc;
                n.mode = is_dig ? MODE_POS : MODE_END;
            end
            MODE_NEG:
            begin
                n.acc  = is_dig ? scale_digit(r.acc, dv, 1'b1) : r.acc;
                n.mode = is_dig ? MODE_NEG : MODE_END;
            end
            default:
            begin
            end
        endcase
        return n;
    endfunction

    // Substring search step: a mismatch restarts on the first pattern character.
    function automatic alp_match_t match_delim(logic [1:0] prog, logic [23:0] pat, int len,
                                               logic [7:0] c);
        alp_match_t m;
        int         p;
        p = int'(prog);
        m.hit = 1'b0;
        if (p < len && c == pat[8*p +: 8])
        begin
            p = p + 1;
            m.hit      = (p == len);
            m.progress = m.hit ? 2'd0 : p[1:0];
        end
        else
        begin
            m.progress = (c == pat[7:0]) ? 2'd1 : 2'd0;
        end
        return m;
    endfunction

    function automatic logic reader_valid(alp_mode_t m);
        return m inside {MODE_POS, MODE_NEG, MODE_END};
    endfunction

    task automatic clear_line_state();
        parse_phase    = PH_SPACE_0;
        delim_progress = 2'd0;
        status_rd      = '{mode: MODE_IDLE, acc: 32'sd0};
        size_rd        = '{mode: MODE_IDLE, acc: 32'sd0};
    endtask

    // Update the predicted state with one accepted byte; queue a result at line end.
    task automatic parse_log_byte(input alp_in_t item);
        logic [7:0]   c;
        alp_match_t   m;
        alp_outcome_t outcome;
        alp_out_t     res;
        c = item.byte_value;
        status_rd = read_digit(status_rd, c);
        size_rd   = read_digit(size_rd, c);
        case (parse_phase)
            PH_SPACE_0, PH_SPACE_1, PH_SPACE_2:
            begin
                if (c == CH_SPACE)
                begin
                    parse_phase = alp_phase_t'(parse_phase + 4'd1);
                end
            end
            PH_REQUEST:
            begin
                m = match_delim(delim_progress, PAT_REQUEST, 3, c);
                delim_progress = m.progress;
                if (m.hit)
                begin
                    parse_phase = PH_STATUS_START;
                end
            end
            PH_STATUS_START:
            begin
                m = match_delim(delim_progress, PAT_STATUS, 2, c);
                delim_progress = m.progress;
                if (m.hit)
                begin
                    parse_phase    = PH_SIZE_START;
                    status_rd.mode = MODE_WS;
                end
            end
            PH_SIZE_START:
            begin
                if (c == CH_SPACE)
                begin
                    parse_phase  = PH_REFERER;
                    size_rd.mode = MODE_WS;
                end
            end
            PH_REFERER:
            begin
                m = match_delim(delim_progress, PAT_REFERER, 2, c);
                delim_progress = m.progress;
                if (m.hit)
                begin
                    parse_phase = PH_AGENT;
                end
            end
            PH_AGENT:
            begin
                m = match_delim(delim_progress, PAT_AGENT, 3, c);
                delim_progress = m.progress;
                if (m.hit)
                begin
                    parse_phase = PH_AGENT_CLOSE;
                end
            end
            PH_AGENT_CLOSE:
            begin
                if (c == CH_QUOTE)
                begin
                    parse_phase = PH_QUOTE_CHECK;
                end
            end
            PH_QUOTE_CHECK:
            begin
                parse_phase = (c == CH_SPACE) ? PH_DONE_BAD : PH_DONE_OK;
            end
            default:
            begin
            end
        endcase

        if (!item.line_end)
        begin
            return;
        end

        // A closing quote on the last byte leaves the quote check pending, which is not a bad agent end.
        if (parse_phase < PH_AGENT_CLOSE)
        begin
            outcome = OUT_DELIM_MISS;
        end
        else if (parse_phase == PH_AGENT_CLOSE || parse_phase == PH_DONE_BAD)
        begin
            outcome = OUT_AGENT_BAD;
        end
        else if (!reader_valid(status_rd.mode) || !reader_valid(size_rd.mode))
        begin
            outcome = OUT_NUMBER_BAD;
        end
        else
        begin
            outcome = OUT_OK;
        end

        line_count = line_count + 32'd1;
        res.line_outcome = outcome;
        res.status_value = 32'sd0;
        res.object_bytes = 32'sd0;
        if (outcome == OUT_OK)
        begin
            res.status_value = status_rd.acc;
            res.object_bytes = size_rd.acc;
            size_total = size_total + {{16{size_rd.acc[31]}}, size_rd.acc};
        end
        res.lines_seen  = line_count;
        res.bytes_total = size_total;
        expected_lines.push_back(res);
        clear_line_state();
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on line result: %s got %0h expected %0h", what, got, want);
        fail_count = fail_count + 1;
    endtask

    // Compare one accepted result with the oldest prediction.
    task automatic check_line_result(input alp_out_t got);
        alp_out_t want;
        if (expected_lines.size() == 0)
        begin
            report_mismatch("result with none predicted, lines_seen", 64'(got.lines_seen),
                            '0);
            return;
        end
        want = expected_lines.pop_front();
        if (got.line_outcome !== want.line_outcome)
        begin
            report_mismatch("line_outcome", 64'(got.line_outcome), 64'(want.line_outcome));
        end
        if (got.status_value !== want.status_value)
        begin
            report_mismatch("status_value", 64'(got.status_value), 64'(want.status_value));
        end
        if (got.object_bytes !== want.object_bytes)
        begin
            report_mismatch("object_bytes", 64'(got.object_bytes), 64'(want.object_bytes));
        end
        if (got.lines_seen !== want.lines_seen)
        begin
            report_mismatch("lines_seen", 64'(got.lines_seen), 64'(want.lines_seen));
        end
        if (got.bytes_total !== want.bytes_total)
        begin
            report_mismatch("bytes_total", 64'(got.bytes_total), 64'(want.bytes_total));
        end
        lines_checked = lines_checked + 1;
        outcome_hits[want.line_outcome] = outcome_hits[want.line_outcome] + 32'd1;
    endtask

    // Watch both channels at every clock edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_line_state();
            line_count    = 32'd0;
            size_total    = 48'd0;
            fail_count    = 0;
            lines_checked = 0;
            outcome_hits  = '0;
            expected_lines.delete();
            pending <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                check_line_result(result_item);
            end
            if (byte_valid && byte_ready)
            begin
                parse_log_byte(byte_item);
            end
            pending <= expected_lines.size();
        end
    end

endmodule

// ===== dv/access_log_line_parser_core_tb.sv =====
// Testbench top for the access-log line parser: stimulus, receiver stalls and verdict.
module access_log_line_parser_core_tb;
    import alp_pkg::*;

    localparam int CYCLE_LIMIT = 250000;

    logic     clk          = 1'b0;
    logic     rst_n        = 1'b0;
    logic     byte_valid   = 1'b0;
    logic     byte_ready;
    alp_in_t  byte_item    = '0;
    logic     result_valid;
    logic     result_ready = 1'b0;
    alp_out_t result_item;

    int               fail_count;
    int               pending;
    int               lines_checked;
    logic [3:0][31:0] outcome_hits;

    // Bytes of the line being built, and stimulus bookkeeping.
    logic [7:0] line_buf[$];
    int         bytes_sent  = 0;
    bit         send_idle   = 1'b0;
    bit         recv_idle   = 1'b0;
    int         ready_hold  = 0;
    int         cycle_count = 0;

    always #6 clk = ~clk;

    access_log_line_parser_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    alp_line_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_ready    (byte_ready),
        .byte_item     (byte_item),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result_item   (result_item),
        .fail_count    (fail_count),
        .pending       (pending),
        .lines_checked (lines_checked),
        .outcome_hits  (outcome_hits)
    );

    // Receiver: ready drops in random bursts while stalls are enabled.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else if (ready_hold != 0)
        begin
            ready_hold <= ready_hold - 1;
        end
        else if (recv_idle && $urandom_range(0, 4) == 0)
        begin
            result_ready <= 1'b0;
            ready_hold   <= $urandom_range(0, 6);
        end
        else
        begin
            result_ready <= 1'b1;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("access_log_line_parser_core_tb NOT OK");
            $finish;
        end
    end

    // Offer one item and hold it until accepted, with an optional gap before it.
    task automatic send_item(input logic [7:0] b, input logic last);
        alp_in_t it;
        if (send_idle && $urandom_range(0, 3) == 0)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        it.byte_value = b;
        it.line_end   = last;
        byte_item  <= it;
        byte_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!byte_ready);
        bytes_sent = bytes_sent + 1;
    endtask

    task automatic send_line();
        foreach (line_buf[i])
        begin
            send_item(line_buf[i], i == line_buf.size() - 1);
        end
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            line_buf.push_back(s[i]);
        end
    endtask

    // A run of characters that are never delimiters.
    task automatic put_token(input int lo, input int hi);
        string alphabet;
        int    n;
        alphabet = "abcdefghijklmnopqrstuvwxyz0123456789/.:-_";
        n = $urandom_range(lo, hi);
        repeat (n)
        begin
            line_buf.push_back(alphabet[$urandom_range(0, alphabet.len() - 1)]);
        end
    endtask

    // A number field: plain, signed, empty, overflowing, padded or malformed.
    task automatic put_number();
        int         pick;
        int         k;
        logic [7:0] pad;
        pick = $urandom_range(0, 12);
        case (pick)
            0: put_text($sformatf("%0d", $urandom_range(100, 599)));
            1:
            begin
                // Empty field: the reader runs on into the text that follows.
            end
            2: put_text("-");
            3: put_text($sformatf("+%0d", $urandom_range(0, 99999)));
            4: put_text($sformatf("-%0d", $urandom_range(0, 99999)));
            5:
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    put_text("-");
                end
                repeat ($urandom_range(10, 13))
                begin
                    line_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                end
            end
            6:
            begin
                // Values at and just past the signed 32-bit limits.
                k = $urandom_range(0, 3);
                case (k)
                    0: put_text("2147483647");
                    1: put_text("2147483648");
                    2: put_text("-2147483648");
                    default: put_text("-2147483649");
                endcase
            end
            7:
            begin
                // Leading white space of every kind, a plain space included.
                k = $urandom_range(0, 5);
                pad = (k == 5) ? CH_SPACE : 8'(CH_TAB + k);
                line_buf.push_back(pad);
                put_text($sformatf("%0d", $urandom_range(0, 999)));
            end
            8: put_text($sformatf("%0dx", $urandom_range(0, 999)));
            9: put_text("x12");
            10: put_text("0");
            11:
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    put_text("+");
                end
                else
                begin
                    put_text("-+5");
                end
            end
            default:
            begin
                repeat ($urandom_range(1, 6))
                begin
                    line_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                end
            end
        endcase
    endtask

    // Mostly well-formed lines with random fields, the rest damaged or pure noise.
    task automatic run_random_lines(input int item_goal, input bit with_idle);
        int         shape;
        int         n;
        int         tail;
        logic [7:0] dropped;
        while (bytes_sent < item_goal)
        begin
            send_idle = with_idle && ($urandom_range(0, 3) != 0);
            recv_idle = with_idle && ($urandom_range(0, 3) != 0);
            line_buf.delete();
            shape = $urandom_range(0, 9);
            if (shape == 9)
            begin
                repeat ($urandom_range(1, 24))
                begin
                    line_buf.push_back(8'($urandom_range(0, 255)));
                end
            end
            else
            begin
                put_token(1, 4);
                put_text(" - ");
                put_token(1, 3);
                put_text(" [");
                put_token(1, 4);
                put_text(" +0] \"");
                put_token(1, 3);
                put_text(" /");
                put_token(0, 4);
                put_text("\" ");
                put_number();
                put_text(" ");
                put_number();
                put_text(" \"");
                put_token(0, 4);
                put_text("\" \"");
                put_token(0, 3);
                if ($urandom_range(0, 1) == 1)
                begin
                    put_text(" ");
                    put_token(1, 3);
                end
                put_text("\"");
                // After the agent: nothing, a space (bad end) or more text.
                tail = $urandom_range(0, 3);
                if (tail == 1)
                begin
                    put_text(" ");
                end
                else if (tail == 2)
                begin
                    put_token(1, 2);
                end
                else if (tail == 3)
                begin
                    put_text(" x");
                end

                case (shape)
                    6:
                    begin
                        n = $urandom_range(1, line_buf.size());
                        while (line_buf.size() > n)
                        begin
                            dropped = line_buf.pop_back();
                        end
                    end
                    7: line_buf[$urandom_range(0, line_buf.size() - 1)] =
                           8'($urandom_range(0, 255));
                    8: line_buf.insert($urandom_range(0, line_buf.size() - 1),
                                       8'($urandom_range(0, 255)));
                    default:
                    begin
                    end
                endcase
            end
            send_line();
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: shortest clean line ending on the agent quote, a lone 0xFF byte,
        // and the shortest line with a space after the agent quote.
        put_text("   ] \"\" 2 5 \"\" \"\"");
        send_line();
        line_buf.delete();
        line_buf.push_back(8'hFF);
        send_line();
        line_buf.delete();
        put_text("   ] \"\" 2 5 \"\" \"\" ");
        send_line();

        // Random lines with idling on both sides, then a closing stretch without any.
        run_random_lines(1700, 1'b1);
        run_random_lines(2000, 1'b0);
        send_idle = 1'b0;
        recv_idle = 1'b0;

        byte_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        $display("sent %0d bytes forming %0d checked lines", bytes_sent, lines_checked);
        $display("outcomes seen: %0d clean, %0d missing delimiter, %0d bad agent end,",
                 outcome_hits[OUT_OK], outcome_hits[OUT_DELIM_MISS],
                 outcome_hits[OUT_AGENT_BAD]);
        $display("               %0d bad number", outcome_hits[OUT_NUMBER_BAD]);
        if (fail_count == 0 && pending == 0)
        begin
            $display("access_log_line_parser_core_tb OK");
        end
        else
        begin
            $display("access_log_line_parser_core_tb NOT OK");
        end
        $finish;
    end

endmodule
